// ----- hdl/eme_pkg.sv -----
`default_nettype none
package eme_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUB = 2'd0,
    MODE_ENC = 2'd1,
    MODE_DEC = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODULUS = 2'd0,
    REG_GENERATOR = 2'd1,
    REG_PRIVATE = 2'd2,
    REG_PEER = 2'd3
  } cfg_idx_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,      // latch item and config, clear results
    OP_REDUCE,    // one restoring step of x mod p
    OP_POW_INIT,  // acc = 1, base = reduced operand, exponent latched
    OP_MUL_INIT,  // start a shift-and-add product
    OP_MUL_STEP,  // one bit of the product
    OP_POW_STEP,  // consume product into acc or base
    OP_DIV_INIT,  // start r0 / r1
    OP_DIV_STEP,  // one quotient bit
    OP_EUC_STEP,  // rotate remainders after q*t1 product
    OP_STORE      // move a value to a result slot or to save
  } op_t;

  // Operand selectors.
  typedef enum logic [2:0] {
    SEL_GEN,
    SEL_PEER,
    SEL_C1,
    SEL_C2,
    SEL_MSG,
    SEL_ACC
  } sel_t;

  typedef enum logic [1:0] {
    EXP_PRIV,
    EXP_EPH
  } exp_sel_t;

  typedef enum logic [1:0] {
    DST_FIRST,
    DST_SECOND,
    DST_SAVE,
    DST_FIRST_ACC   // finished power straight into the first result
  } dst_t;

  typedef enum logic [2:0] {
    PM_ACC,      // acc * base
    PM_SQR,      // base * base
    PM_SAVE_RED, // save * red
    PM_QT,       // (q mod p) * t1
    PM_C2_INV    // red * t0
  } pm_t;

  typedef struct packed {
    op_t      op;
    sel_t     sel;
    exp_sel_t exp_sel;
    dst_t     dst;
    pm_t      pm;
    logic     set_status;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  p_small;   // modulus below two
    logic  red_done;
    logic  mul_done;
    logic  exp_zero;
    logic  exp_bit;
    logic  div_done;
    logic  r1_zero;
    logic  r0_one;
    logic  acc_zero;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_START,
    ST_RED,
    ST_POW_INIT,
    ST_POW_TEST,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_END,
    ST_MSG_RED,
    ST_MSG_MUL,
    ST_INV_START,
    ST_DIV,
    ST_QT_MUL,
    ST_EUC,
    ST_INV_END,
    ST_C2_RED,
    ST_C2_MUL,
    ST_FAIL,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/eme_datapath.sv -----
`default_nettype none
module eme_datapath #(
  parameter int unsigned WIDTH = eme_pkg::DefWidth
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire eme_pkg::cmd_t          cmd,
  output eme_pkg::sts_t               sts,
  input  wire logic [WIDTH-1:0]       p_i,
  input  wire logic [WIDTH-1:0]       g_i,
  input  wire logic [WIDTH-1:0]       priv_i,
  input  wire logic [WIDTH-1:0]       peer_i,
  input  wire logic [1:0]             mode_i,
  input  wire logic [WIDTH-1:0]       msg_i,
  input  wire logic [WIDTH-1:0]       eph_i,
  input  wire logic [WIDTH-1:0]       c1_i,
  input  wire logic [WIDTH-1:0]       c2_i,
  output logic [WIDTH-1:0]            first_o,
  output logic [WIDTH-1:0]            second_o,
  output logic                        status_o
);
  import eme_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  mode_t            mode_r;
  logic [WIDTH-1:0] p_r, g_r, priv_r, peer_r, msg_r, eph_r, c1_r, c2_r;
  logic [WIDTH-1:0] acc_r, base_r, exp_r, save_r, red_r;
  logic [WIDTH-1:0] ma_r, mb_r, mp_r;         // product: multiplicand, multiplier, partial
  logic [WIDTH-1:0] r0_r, r1_r, t0_r, t1_r, q_r, rem_r, dsh_r;
  logic [WIDTH-1:0] rsh_r;                    // reduction shift register
  logic [CntW-1:0]  cnt_r;
  logic [WIDTH-1:0] first_r, second_r;
  logic             status_r;

  // (a + b) mod p for a, b < p
  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] a,
                                            input logic [WIDTH-1:0] b,
                                            input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  logic [WIDTH-1:0] sel_v, pm_a, pm_b;
  logic [WIDTH:0]   red_sh, div_sh;

  always_comb begin
    sel_v = '0;
    unique case (cmd.sel)
      SEL_GEN:  sel_v = g_r;
      SEL_PEER: sel_v = peer_r;
      SEL_C1:   sel_v = c1_r;
      SEL_C2:   sel_v = c2_r;
      SEL_MSG:  sel_v = msg_r;
      SEL_ACC:  sel_v = acc_r;
      default:  sel_v = '0;
    endcase
    pm_a = acc_r;
    pm_b = base_r;
    unique case (cmd.pm)
      PM_ACC:      begin pm_a = acc_r;  pm_b = base_r; end
      PM_SQR:      begin pm_a = base_r; pm_b = base_r; end
      PM_SAVE_RED: begin pm_a = save_r; pm_b = red_r;  end
      // A Euclid quotient never exceeds p, so one subtraction reduces it.
      PM_QT:       begin pm_a = (q_r >= p_r) ? (q_r - p_r) : q_r; pm_b = t1_r; end
      PM_C2_INV:   begin pm_a = red_r;  pm_b = t0_r;   end
      default:     begin pm_a = acc_r;  pm_b = base_r; end
    endcase
    red_sh = {red_r, rsh_r[WIDTH-1]};
    div_sh = {rem_r, dsh_r[WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          mode_r <= mode_t'(mode_i);
          p_r <= p_i; g_r <= g_i; priv_r <= priv_i; peer_r <= peer_i;
          msg_r <= msg_i; eph_r <= eph_i; c1_r <= c1_i; c2_r <= c2_i;
          first_r <= '0; second_r <= '0; status_r <= 1'b0;
        end
        OP_REDUCE: begin
          // Bit-serial restoring reduction of rsh into red.
          if (cnt_r == '0) begin
            rsh_r <= sel_v;
            red_r <= '0;
            cnt_r <= CntW'(WIDTH);
          end else begin
            rsh_r <= rsh_r << 1;
            red_r <= (red_sh >= {1'b0, p_r}) ? WIDTH'(red_sh - {1'b0, p_r})
                                             : red_sh[WIDTH-1:0];
            cnt_r <= cnt_r - 1'b1;
          end
        end
        OP_POW_INIT: begin
          acc_r  <= WIDTH'(1);
          base_r <= red_r;
          exp_r  <= (cmd.exp_sel == EXP_PRIV) ? priv_r : eph_r;
        end
        OP_MUL_INIT: begin
          ma_r <= pm_a;
          mb_r <= pm_b;
          mp_r <= '0;
        end
        OP_MUL_STEP: begin
          if (mb_r[0]) mp_r <= addm(mp_r, ma_r, p_r);
          ma_r <= addm(ma_r, ma_r, p_r);
          mb_r <= mb_r >> 1;
        end
        OP_POW_STEP: begin
          unique case (cmd.pm)
            PM_ACC:  acc_r  <= mp_r;
            PM_SQR:  begin base_r <= mp_r; exp_r <= exp_r >> 1; end
            default: acc_r  <= mp_r;
          endcase
        end
        OP_DIV_INIT: begin
          if (cmd.sel == SEL_ACC) begin
            // Start extended Euclid: r0 = p, r1 = s, t0 = 0, t1 = 1.
            r0_r <= p_r; r1_r <= acc_r; t0_r <= '0; t1_r <= WIDTH'(1);
            dsh_r <= p_r;
          end else begin
            dsh_r <= r0_r;
          end
          rem_r <= '0;
          q_r   <= '0;
          cnt_r <= CntW'(WIDTH);
        end
        OP_DIV_STEP: begin
          dsh_r <= dsh_r << 1;
          if (div_sh >= {1'b0, r1_r}) begin
            rem_r <= WIDTH'(div_sh - {1'b0, r1_r});
            q_r   <= {q_r[WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= div_sh[WIDTH-1:0];
            q_r   <= {q_r[WIDTH-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
        end
        OP_EUC_STEP: begin
          r0_r <= r1_r;
          r1_r <= rem_r;
          t0_r <= t1_r;
          t1_r <= addm(t0_r, (mp_r == '0) ? '0 : (p_r - mp_r), p_r);
        end
        OP_STORE: begin
          unique case (cmd.dst)
            DST_FIRST:     first_r  <= mp_r;
            DST_SECOND:    second_r <= mp_r;
            DST_SAVE:      save_r   <= acc_r;
            DST_FIRST_ACC: first_r  <= acc_r;
            default:       save_r   <= acc_r;
          endcase
        end
        default: ;
      endcase
      if (cmd.set_status) status_r <= 1'b1;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.p_small  = (p_r < WIDTH'(2));
  assign sts.red_done = (cnt_r == CntW'(1)) && (cmd.op == OP_REDUCE);
  assign sts.mul_done = (mb_r == '0);
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_bit  = exp_r[0];
  assign sts.div_done = (cnt_r == '0);
  assign sts.r1_zero  = (r1_r == '0);
  assign sts.r0_one   = (r0_r == WIDTH'(1));
  assign sts.acc_zero = (acc_r == '0);

  assign first_o  = first_r;
  assign second_o = second_r;
  assign status_o = status_r;

endmodule
`default_nettype wire

// ----- hdl/eme_controller.sv -----
`default_nettype none
module eme_controller (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start_i,
  input  wire logic           out_free_i,
  output logic                busy_o,
  output logic                done_o,
  output eme_pkg::cmd_t       cmd,
  input  wire eme_pkg::sts_t  sts
);
  import eme_pkg::*;

  // Which exponentiation or product is under way.
  typedef enum logic [2:0] {
    PH_PUB,
    PH_C1,
    PH_PEER,
    PH_DEC
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   sqr_r, sqr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_PUB;
      sqr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      sqr_r   <= sqr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    sqr_nxt   = sqr_r;
    cmd       = '{op: OP_NOP, sel: SEL_GEN, exp_sel: EXP_PRIV, dst: DST_FIRST,
                  pm: PM_ACC, set_status: 1'b0};
    busy_o    = (state_r != ST_IDLE);
    done_o    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // The word is latched at the edge where it is accepted.
        if (start_i) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.p_small || sts.mode == MODE_NONE) begin
          if (sts.mode == MODE_DEC) cmd.set_status = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          unique case (sts.mode)
            MODE_PUB: phase_nxt = PH_PUB;
            MODE_ENC: phase_nxt = PH_C1;
            default:  phase_nxt = PH_DEC;
          endcase
          state_nxt = ST_RED_START;
        end
      end
      ST_RED_START: begin
        cmd.op = OP_REDUCE;
        unique case (phase_r) inside
          PH_PUB, PH_C1: cmd.sel = SEL_GEN;
          PH_PEER:       cmd.sel = SEL_PEER;
          default:       cmd.sel = SEL_C1;
        endcase
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.op = OP_REDUCE;
        if (sts.red_done) state_nxt = ST_POW_INIT;
      end
      ST_POW_INIT: begin
        cmd.op = OP_POW_INIT;
        cmd.exp_sel = (phase_r == PH_C1 || phase_r == PH_PEER) ? EXP_EPH : EXP_PRIV;
        state_nxt = ST_POW_TEST;
      end
      ST_POW_TEST: begin
        if (sts.exp_zero) begin
          state_nxt = ST_POW_END;
        end else begin
          cmd.op = OP_MUL_INIT;
          sqr_nxt = !sts.exp_bit;
          cmd.pm  = sts.exp_bit ? PM_ACC : PM_SQR;
          state_nxt = ST_POW_MUL;
        end
      end
      ST_POW_MUL: begin
        if (sts.mul_done) begin
          cmd.op = OP_POW_STEP;
          cmd.pm = sqr_r ? PM_SQR : PM_ACC;
          state_nxt = sqr_r ? ST_POW_TEST : ST_POW_SQR;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_POW_SQR: begin
        cmd.op = OP_MUL_INIT;
        cmd.pm = PM_SQR;
        sqr_nxt = 1'b1;
        state_nxt = ST_POW_MUL;
      end
      ST_POW_END: begin
        unique case (phase_r)
          PH_PUB: begin
            cmd.op = OP_STORE;
            cmd.dst = DST_FIRST_ACC;
            state_nxt = ST_OUT;
          end
          PH_C1: begin
            // c1 is finished; the power of the peer key comes next.
            cmd.op = OP_STORE;
            cmd.dst = DST_FIRST_ACC;
            phase_nxt = PH_PEER;
            state_nxt = ST_RED_START;
          end
          PH_PEER: begin
            cmd.op = OP_STORE;
            cmd.dst = DST_SAVE;
            state_nxt = ST_MSG_RED;
          end
          default: begin
            if (sts.acc_zero) state_nxt = ST_FAIL;
            else state_nxt = ST_INV_START;
          end
        endcase
      end
      ST_MSG_RED: begin
        cmd.op = OP_REDUCE;
        cmd.sel = SEL_MSG;
        if (sts.red_done) begin
          sqr_nxt = 1'b0;
          state_nxt = ST_C2_MUL;
          cmd.op = OP_REDUCE;
        end
      end
      ST_MSG_MUL: begin
        // Finish the reduction of c2 before the final product.
        cmd.op = OP_REDUCE;
        if (sts.red_done) begin
          sqr_nxt = 1'b1;
          state_nxt = ST_C2_MUL;
        end
      end
      ST_C2_MUL: begin
        cmd.op = OP_MUL_INIT;
        cmd.pm = PM_SAVE_RED;
        state_nxt = ST_C2_RED;
      end
      ST_C2_RED: begin
        if (sts.mul_done) begin
          cmd.op = OP_STORE;
          if (phase_r == PH_PEER) cmd.dst = DST_SECOND;
          else cmd.dst = DST_FIRST;
          state_nxt = ST_OUT;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_INV_START: begin
        cmd.op = OP_DIV_INIT;
        cmd.sel = SEL_ACC;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_QT_MUL;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      ST_QT_MUL: begin
        cmd.op = OP_MUL_INIT;
        cmd.pm = PM_QT;
        state_nxt = ST_EUC;
      end
      ST_EUC: begin
        if (sts.mul_done) begin
          cmd.op = OP_EUC_STEP;
          state_nxt = ST_INV_END;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_INV_END: begin
        if (!sts.r1_zero) begin
          cmd.op = OP_DIV_INIT;
          cmd.sel = SEL_GEN;
          state_nxt = ST_DIV;
        end else if (!sts.r0_one) begin
          state_nxt = ST_FAIL;
        end else begin
          cmd.op = OP_REDUCE;
          cmd.sel = SEL_C2;
          state_nxt = ST_MSG_MUL;
          phase_nxt = PH_DEC;
        end
      end
      ST_FAIL: begin
        cmd.set_status = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        done_o = 1'b1;
        if (out_free_i) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_C2_MUL && phase_r == PH_DEC) cmd.pm = PM_C2_INV;
  end

endmodule
`default_nettype wire

// ----- hdl/elgamal_modular_engine.sv -----
`default_nettype none
// ElGamal engine over a prime modulus p held in configuration. Each input word
// carries a mode: public key (g^x mod p), encryption (c1 = g^k, c2 = y^k * m mod p)
// or decryption (m = c2 * (c1^x)^-1 mod p, status set when the shared secret has
// no inverse). One word is in flight at a time and is latched when accepted. An
// item goes straight from the check to the output for a degenerate modulus or the
// unused mode; otherwise its run time is set by the single bit-serial
// add-and-double multiplier and the bit-serial divider in the datapath.
// Configuration may be written only while the engine is idle.
module elgamal_modular_engine #(
  parameter int unsigned WIDTH = eme_pkg::DefWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [eme_pkg::ModeW-1:0]     in_mode,
  input  wire logic [WIDTH-1:0]              in_message,
  input  wire logic [WIDTH-1:0]              in_ephemeral_key,
  input  wire logic [WIDTH-1:0]              in_cipher_first,
  input  wire logic [WIDTH-1:0]              in_cipher_second,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [eme_pkg::OutW-1:0]           out_result_first,
  output logic [eme_pkg::OutW-1:0]           out_result_second,
  output logic                               out_status,
  input  wire logic                          cfg_we,
  input  wire logic [eme_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [WIDTH-1:0]              cfg_data
);
  import eme_pkg::*;

  logic [WIDTH-1:0] modulus_r, generator_r, private_key_r, peer_public_key_r;
  logic [WIDTH-1:0] first_w, second_w;
  logic             status_w, busy_w, done_w;
  cmd_t             cmd_w;
  sts_t             sts_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r         <= WIDTH'(11);
      generator_r       <= WIDTH'(2);
      private_key_r     <= WIDTH'(5);
      peer_public_key_r <= WIDTH'(10);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODULUS:   modulus_r         <= cfg_data;
        REG_GENERATOR: generator_r       <= cfg_data;
        REG_PRIVATE:   private_key_r     <= cfg_data;
        REG_PEER:      peer_public_key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy_w;

  eme_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_valid),
    .out_free_i (!out_stall),
    .busy_o     (busy_w),
    .done_o     (done_w),
    .cmd        (cmd_w),
    .sts        (sts_w)
  );

  eme_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_w),
    .sts      (sts_w),
    .p_i      (modulus_r),
    .g_i      (generator_r),
    .priv_i   (private_key_r),
    .peer_i   (peer_public_key_r),
    .mode_i   (in_mode),
    .msg_i    (in_message),
    .eph_i    (in_ephemeral_key),
    .c1_i     (in_cipher_first),
    .c2_i     (in_cipher_second),
    .first_o  (first_w),
    .second_o (second_w),
    .status_o (status_w)
  );

  assign out_valid         = done_w;
  assign out_result_first  = OutW'(first_w);
  assign out_result_second = OutW'(second_w);
  assign out_status        = status_w;

  // A word is only offered while the engine is busy.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result word offered while idle");

  // Second result is nonzero only for encryption.
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_second != '0) |-> (sts_w.mode == MODE_ENC))
    else $error("second result set outside encryption");

  // Status is set only in decryption.
  a_status_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (sts_w.mode == MODE_DEC))
    else $error("status set outside decryption");

endmodule
`default_nettype wire

// ----- tb/sv/elgamal_modular_engine_test.sv -----
`timescale 1ns / 100ps

module elgamal_modular_engine_test;
  import eme_pkg::*;

  // One input word as the sender offers it.
  typedef struct {
    mode_t       mode;
    logic [31:0] msg;
    logic [31:0] eph;
    logic [31:0] c1;
    logic [31:0] c2;
  } op_word_t;

  // One result word as the engine should deliver it.
  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_message = '0;
  logic [31:0] in_ephemeral_key = '0;
  logic [31:0] in_cipher_first = '0;
  logic [31:0] in_cipher_second = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_first;
  logic [31:0] out_result_second;
  logic        out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Control flags from the stimulus process, written with nonblocking
  // assignments so the clocked driver and monitor see them from the following edge.
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  // Our copy of the configuration registers, reset values as in the engine.
  logic [31:0] grp_p = 32'd11;
  logic [31:0] grp_g = 32'd2;
  logic [31:0] own_x = 32'd5;
  logic [31:0] peer_y = 32'd10;

  op_word_t words_pending[$];
  answer_t  answers_due[$];
  int       errors = 0;

  elgamal_modular_engine dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_message, .in_ephemeral_key,
    .in_cipher_first, .in_cipher_second,
    .out_valid, .out_stall, .out_result_first, .out_result_second, .out_status,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Modular arithmetic on 64-bit containers. Operands stay below 2^32, so the
  // product never overflows.
  function automatic logic [63:0] mul_p(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic logic [63:0] pow_p(logic [63:0] b, logic [31:0] e, logic [63:0] p);
    logic [63:0] acc;
    acc = 64'd1 % p;
    b = b % p;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) acc = mul_p(acc, b, p);
      b = mul_p(b, b, p);
    end
    return acc;
  endfunction

  // Extended Euclid on signed values. Returns 0 when no inverse exists.
  function automatic bit inv_p(logic [63:0] a, logic [63:0] p, output logic [63:0] inv);
    longint r0, r1, t0, t1, q, tmp;
    r0 = p; r1 = a; t0 = 0; t1 = 1;
    inv = '0;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 = t0 + longint'(p);
    inv = t0;
    return 1'b1;
  endfunction

  function automatic answer_t elgamal_answer(op_word_t w);
    answer_t     r;
    logic [63:0] p, s, inv;
    p = 64'(grp_p);
    r.first = '0; r.second = '0; r.status = 1'b0;
    if (p < 2) begin
      // Degenerate group: every residue collapses to zero.
      r.status = (w.mode == MODE_DEC);
    end else begin
      case (w.mode)
        MODE_PUB: r.first = 32'(pow_p(64'(grp_g), own_x, p));
        MODE_ENC: begin
          r.first = 32'(pow_p(64'(grp_g), w.eph, p));
          r.second = 32'(mul_p(pow_p(64'(peer_y), w.eph, p), 64'(w.msg), p));
        end
        MODE_DEC: begin
          s = pow_p(64'(w.c1), own_x, p);
          if (s != 0 && inv_p(s, p, inv)) r.first = 32'(mul_p(64'(w.c2), inv, p));
          else r.status = 1'b1;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: offers queued words, with random idle bursts between them. The
  // prediction is taken at the edge where a word is accepted.
  int       send_gap = 0;
  op_word_t offered;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) answers_due.push_back(elgamal_answer(offered));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          send_gap <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (words_pending.size() != 0) begin
          offered = words_pending.pop_front();
          in_valid <= 1'b1;
          in_mode <= offered.mode;
          in_message <= offered.msg;
          in_ephemeral_key <= offered.eph;
          in_cipher_first <= offered.c1;
          in_cipher_second <= offered.c2;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall bursts, plus one long hold-off on request so the
  // engine finishes a word, cannot hand it over, and stalls its input.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  answer_t want;

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        report("unexpected result word", out_result_first, '0);
      end else begin
        want = answers_due.pop_front();
        if (out_result_first !== want.first) report("result_first", out_result_first, want.first);
        if (out_result_second !== want.second)
          report("result_second", out_result_second, want.second);
        if (out_status !== want.status)
          report("status", 32'(out_status), 32'(want.status));
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 6000;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODULUS:   grp_p = val;
      REG_GENERATOR: grp_g = val;
      REG_PRIVATE:   own_x = val;
      default:       peer_y = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_word(mode_t m, logic [31:0] msg, logic [31:0] eph,
                            logic [31:0] c1, logic [31:0] c2);
    op_word_t w;
    w.mode = m; w.msg = msg; w.eph = eph; w.c1 = c1; w.c2 = c2;
    words_pending.push_back(w);
  endtask

  // Wait until every word has gone in and every answer has come back, then
  // let the engine settle before the next register write.
  task automatic drain();
    while (words_pending.size() != 0 || in_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // A random word; most decrypts are built from a fresh encryption so they
  // take the full inverse path, the rest carry noise.
  task automatic queue_random();
    logic [31:0] k, m, c1, c2;
    k = rnd_word(); m = rnd_word();
    case ($urandom_range(0, 9)) inside
      [0:1]: queue_word(MODE_PUB, $urandom, $urandom, $urandom, $urandom);
      [2:4]: queue_word(MODE_ENC, m, k, $urandom, $urandom);
      [5:7]: begin
        if (grp_p >= 2) begin
          c1 = 32'(pow_p(64'(grp_g), k, 64'(grp_p)));
          c2 = 32'(mul_p(pow_p(64'(peer_y), k, 64'(grp_p)), 64'(m), 64'(grp_p)));
        end else begin
          c1 = $urandom; c2 = $urandom;
        end
        queue_word(MODE_DEC, $urandom, $urandom, c1, c2);
      end
      8: queue_word(MODE_DEC, $urandom, $urandom, rnd_word(), rnd_word());
      default: queue_word(MODE_NONE, $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  int unsigned small_primes[10] = '{2, 3, 5, 7, 11, 13, 101, 251, 65521, 65537};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset configuration (p = 11).
    queue_word(MODE_PUB, '0, '0, '0, '0);
    queue_word(MODE_ENC, 32'd7, 32'd3, '0, '0);
    queue_word(MODE_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(MODE_ENC, 32'd9, '0, '0, '0);             // exponent zero
    queue_word(MODE_DEC, '0, '0, 32'd6, 32'd3);
    queue_word(MODE_DEC, '0, '0, '0, 32'd5);             // secret is zero
    queue_word(MODE_DEC, '0, '0, 32'd22, 32'd5);         // secret is a multiple of p
    queue_word(MODE_DEC, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Largest 32-bit prime with all-ones operands.
    write_reg(REG_MODULUS, 32'hFFFF_FFFB);
    write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
    write_reg(REG_PRIVATE, 32'hFFFF_FFFF);
    write_reg(REG_PEER, 32'hFFFF_FFFF);
    queue_word(MODE_PUB, '0, '0, '0, '0);
    queue_word(MODE_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    queue_word(MODE_DEC, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Modulus below two, both values, then the smallest real group with
    // zero generator and zero key.
    write_reg(REG_MODULUS, '0);
    queue_word(MODE_PUB, 32'd1, 32'd1, 32'd1, 32'd1);
    queue_word(MODE_ENC, 32'd1, 32'd1, 32'd1, 32'd1);
    queue_word(MODE_DEC, 32'd1, 32'd1, 32'd1, 32'd1);
    drain();
    write_reg(REG_MODULUS, 32'd1);
    queue_word(MODE_DEC, '0, '0, 32'd3, 32'd3);
    queue_word(MODE_ENC, 32'd5, 32'd5, '0, '0);
    drain();
    write_reg(REG_MODULUS, 32'd2);
    write_reg(REG_GENERATOR, '0);
    write_reg(REG_PRIVATE, '0);
    write_reg(REG_PEER, '0);
    queue_word(MODE_PUB, '0, '0, '0, '0);
    queue_word(MODE_ENC, 32'd1, '0, '0, '0);
    queue_word(MODE_DEC, '0, '0, '0, 32'd1);
    queue_word(MODE_DEC, '0, '0, 32'd1, 32'd1);
    drain();

    // Random phases. Mostly small primes keep the Euclid loop short; a few
    // use a full-width or composite modulus.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_MODULUS, $urandom | 32'h8000_0001);
        1: write_reg(REG_MODULUS, $urandom_range(4, 1000));
        default: write_reg(REG_MODULUS, small_primes[$urandom_range(0, 9)]);
      endcase
      write_reg(REG_GENERATOR, rnd_word());
      write_reg(REG_PRIVATE, rnd_word());
      write_reg(REG_PEER, rnd_word());
      if (ph == 6) begin
        @(posedge clk);
        quiet <= 1'b1;
      end
      if (ph == 2) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end
      repeat (10) queue_random();
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/eme_pkg.sv
hdl/eme_datapath.sv
hdl/eme_controller.sv
hdl/elgamal_modular_engine.sv
tb/sv/elgamal_modular_engine_test.sv
